// ----- design/gbrc_pkg.sv -----
// ----------------------------------------------------------------------------
// gbrc_pkg
// Shared types, register codes and limits of the glyph blitter.
// ----------------------------------------------------------------------------
package gbrc_pkg;

	localparam int FB_MAX_SIDE       = 4096;
	localparam int GLYPH_MAX_SIDE_DEF = 64;

	localparam int FB_REG_W    = 13;
	localparam int DEPTH_REG_W = 3;
	localparam int GLYPH_REG_W = 7;
	localparam int MODE_REG_W  = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int COORD_W     = 16;
	localparam int COLOR_W     = 32;
	localparam int ADDR_W      = 26;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 64;

	// depth at which the alpha byte is written
	localparam int DEPTH_ALPHA = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FB_WIDTH     = 3'd0,
		REG_FB_HEIGHT    = 3'd1,
		REG_BYTES_PER_PX = 3'd2,
		REG_GLYPH_WIDTH  = 3'd3,
		REG_GLYPH_HEIGHT = 3'd4,
		REG_PAINT_MODE   = 3'd5
	} cfg_reg_t;

	typedef enum logic [MODE_REG_W-1:0] {
		PAINT_SET   = 2'd0,
		PAINT_CLEAR = 2'd1,
		PAINT_BOTH  = 2'd2
	} paint_mode_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	localparam logic [FB_REG_W-1:0]    RST_FB_WIDTH     = 13'd640;
	localparam logic [FB_REG_W-1:0]    RST_FB_HEIGHT    = 13'd480;
	localparam logic [DEPTH_REG_W-1:0] RST_BYTES_PER_PX = 3'd4;
	localparam logic [GLYPH_REG_W-1:0] RST_GLYPH_WIDTH  = 7'd10;
	localparam logic [GLYPH_REG_W-1:0] RST_GLYPH_HEIGHT = 7'd10;

	typedef struct packed {
		logic [FB_REG_W-1:0]    fb_width;
		logic [FB_REG_W-1:0]    fb_height;
		logic [DEPTH_REG_W-1:0] bytes_per_pixel;
		logic [GLYPH_REG_W-1:0] glyph_width;
		logic [GLYPH_REG_W-1:0] glyph_height;
		logic [MODE_REG_W-1:0]  paint_mode;
	} cfg_t;

	typedef struct packed {
		logic                      glyph_bit;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic [1:0]                rotation;
		logic [COLOR_W-1:0]        fg_color;
		logic [COLOR_W-1:0]        bg_color;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pixel_byte_addr;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [7:0]        alpha;
		logic              write_alpha;
	} pix_t;

endpackage

// ----- design/glyph_blit_rotate_clip.sv -----
// ----------------------------------------------------------------------------
// glyph_blit_rotate_clip
// Streaming glyph blitter: one bitmap bit in, at most one framebuffer write out.
// ----------------------------------------------------------------------------
// Each input item is one glyph bit in row-major order with the glyph origin,
// rotation and colours. An internal column/row counter places the bit in the
// glyph; the place is rotated into the frame, clipped, and filtered by the paint
// mode. A visible painted pixel leaves as one item with its column-major byte
// address and colour bytes; others leave nothing but still advance the counter.
// One item is taken every clock while the output does not stall; an input
// register, then a result register hold the work; the path between them is the
// coordinate add, one 13x13 multiply and the depth scaling. Configuration must
// be written only while no item is in flight; the block does not enforce it.
module glyph_blit_rotate_clip #(
	parameter int GLYPH_MAX_SIDE = gbrc_pkg::GLYPH_MAX_SIDE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// glyph_bit[0], origin_x[16:1], origin_y[32:17], rotation[34:33],
	// fg_color[66:35], bg_color[98:67], zeros[103:99]
	input  logic [gbrc_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pixel_byte_addr[25:0], red[33:26], green[41:34], blue[49:42],
	// alpha[57:50], zeros[63:58]
	output logic [gbrc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// write_alpha[0]
	output logic                                m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic [gbrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW  = $clog2(GLYPH_MAX_SIDE);
	localparam int GSW = CW + 1;

	gbrc_pkg::cfg_t  cfg_q;
	gbrc_pkg::item_t item_in, item_s1;
	gbrc_pkg::pix_t  pix, pix_q;
	logic [CW-1:0]   col, row, col_s1, row_s1;
	logic [GSW-1:0]  gw, gh;
	logic            valid_s1, m_valid_q, visible;
	logic            accept, out_load, s1_go;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width        <= gbrc_pkg::RST_FB_WIDTH;
			cfg_q.fb_height       <= gbrc_pkg::RST_FB_HEIGHT;
			cfg_q.bytes_per_pixel <= gbrc_pkg::RST_BYTES_PER_PX;
			cfg_q.glyph_width     <= gbrc_pkg::RST_GLYPH_WIDTH;
			cfg_q.glyph_height    <= gbrc_pkg::RST_GLYPH_HEIGHT;
			cfg_q.paint_mode      <= gbrc_pkg::PAINT_SET;
		end else if (cfg_we) begin
			case (cfg_index)
				gbrc_pkg::REG_FB_WIDTH:     cfg_q.fb_width <= cfg_data;
				gbrc_pkg::REG_FB_HEIGHT:    cfg_q.fb_height <= cfg_data;
				gbrc_pkg::REG_BYTES_PER_PX:
					cfg_q.bytes_per_pixel <= cfg_data[gbrc_pkg::DEPTH_REG_W-1:0];
				gbrc_pkg::REG_GLYPH_WIDTH:
					cfg_q.glyph_width <= cfg_data[gbrc_pkg::GLYPH_REG_W-1:0];
				gbrc_pkg::REG_GLYPH_HEIGHT:
					cfg_q.glyph_height <= cfg_data[gbrc_pkg::GLYPH_REG_W-1:0];
				gbrc_pkg::REG_PAINT_MODE:
					cfg_q.paint_mode <= cfg_data[gbrc_pkg::MODE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// glyph size clamped to 1..GLYPH_MAX_SIDE
	always_comb begin
		if (cfg_q.glyph_width == '0) begin
			gw = GSW'(1);
		end else if (32'(cfg_q.glyph_width) > GLYPH_MAX_SIDE) begin
			gw = GSW'(GLYPH_MAX_SIDE);
		end else begin
			gw = GSW'(cfg_q.glyph_width);
		end
		if (cfg_q.glyph_height == '0) begin
			gh = GSW'(1);
		end else if (32'(cfg_q.glyph_height) > GLYPH_MAX_SIDE) begin
			gh = GSW'(GLYPH_MAX_SIDE);
		end else begin
			gh = GSW'(cfg_q.glyph_height);
		end
	end

	always_comb begin
		item_in.glyph_bit = s_tdata[0];
		item_in.origin_x  = s_tdata[16:1];
		item_in.origin_y  = s_tdata[32:17];
		item_in.rotation  = s_tdata[34:33];
		item_in.fg_color  = s_tdata[66:35];
		item_in.bg_color  = s_tdata[98:67];
	end

	// an item with no result leaves stage 1 regardless of the output side
	assign out_load = !m_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!visible || out_load);
	assign s_tready = !valid_s1 || s1_go;
	assign accept   = s_tvalid && s_tready;

	gbrc_counter #(
		.GLYPH_MAX_SIDE(GLYPH_MAX_SIDE)
	) u_counter (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.gw      (gw),
		.gh      (gh),
		.col     (col),
		.row     (row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			col_s1  <= col;
			row_s1  <= row;
		end
	end

	gbrc_map #(
		.GLYPH_MAX_SIDE(GLYPH_MAX_SIDE)
	) u_map (
		.item    (item_s1),
		.cfg     (cfg_q),
		.col     (col_s1),
		.row     (row_s1),
		.gw      (gw),
		.gh      (gh),
		.visible (visible),
		.pix     (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= valid_s1 && visible;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1 && visible) begin
			pix_q <= pix;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = pix_q.write_alpha;
	assign m_tdata  = {6'd0, pix_q.alpha, pix_q.blue, pix_q.green, pix_q.red,
		pix_q.pixel_byte_addr};

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item missing from stage 1");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("result appeared without an item in stage 1");

	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready) |=> $stable(col) && $stable(row))
		else $error("glyph counter moved without an accepted item");

	a_counter_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (({1'b0, col} + GSW'(1)) >= gw) |=> col == '0)
		else $error("glyph column did not wrap at the glyph width");

	a_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[57:50] == 8'd0)
		else $error("alpha byte set while alpha is not written");
`endif

endmodule

// ----- design/gbrc_counter.sv -----
// ----------------------------------------------------------------------------
// gbrc_counter
// Column and row place of the next glyph bit, wrapping at the glyph size.
// ----------------------------------------------------------------------------
module gbrc_counter #(
	parameter int GLYPH_MAX_SIDE = gbrc_pkg::GLYPH_MAX_SIDE_DEF,
	localparam int CW  = $clog2(GLYPH_MAX_SIDE),
	localparam int GSW = CW + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [GSW-1:0] gw,
	input  logic [GSW-1:0] gh,
	output logic [CW-1:0]  col,
	output logic [CW-1:0]  row
);

	logic [CW-1:0]  col_q, row_q;
	logic [GSW-1:0] col_inc, row_inc;

	assign col_inc = {1'b0, col_q} + GSW'(1);
	assign row_inc = {1'b0, row_q} + GSW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= gw) begin
				col_q <= '0;
				// a row held past a shrunk glyph also wraps here
				if (row_inc >= gh) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CW-1:0];
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

// ----- design/gbrc_map.sv -----
// ----------------------------------------------------------------------------
// gbrc_map
// Rotation of the glyph place into the frame, clipping, paint decision,
// column-major byte address and colour bytes.
// ----------------------------------------------------------------------------
module gbrc_map #(
	parameter int GLYPH_MAX_SIDE = gbrc_pkg::GLYPH_MAX_SIDE_DEF,
	localparam int CW  = $clog2(GLYPH_MAX_SIDE),
	localparam int GSW = CW + 1
) (
	input  gbrc_pkg::item_t  item,
	input  gbrc_pkg::cfg_t   cfg,
	input  logic [CW-1:0]    col,
	input  logic [CW-1:0]    row,
	input  logic [GSW-1:0]   gw,
	input  logic [GSW-1:0]   gh,
	output logic             visible,
	output gbrc_pkg::pix_t   pix
);

	localparam int XW = GSW + 17;
	localparam int FW = gbrc_pkg::FB_REG_W;
	localparam int AW = gbrc_pkg::ADDR_W;
	localparam logic signed [XW-1:0] ONE = XW'(1);

	logic signed [XW-1:0] ox, oy, cs, rs, gw_m1, gh_m1, px, py;
	logic [FW-1:0]        fw, fh;
	logic                 paint, wa;
	logic [gbrc_pkg::COLOR_W-1:0] color;
	logic [2*FW-1:0]      prod;
	logic [AW-1:0]        lin, addr;

	always_comb begin
		ox    = XW'(item.origin_x);
		oy    = XW'(item.origin_y);
		cs    = $signed(XW'(col));
		rs    = $signed(XW'(row));
		gw_m1 = $signed(XW'(gw)) - ONE;
		gh_m1 = $signed(XW'(gh)) - ONE;

		case (item.rotation)
			gbrc_pkg::ROT_0: begin
				px = ox + cs;
				py = oy + rs;
			end
			gbrc_pkg::ROT_90: begin
				px = ox + gw_m1 - rs;
				py = oy + cs;
			end
			gbrc_pkg::ROT_180: begin
				px = ox + gw_m1 - cs;
				py = oy + gh_m1 - rs;
			end
			default: begin
				px = ox + rs;
				py = oy + gh_m1 - cs;
			end
		endcase
	end

	// frame size clamped to 1..FB_MAX_SIDE
	always_comb begin
		if (cfg.fb_width == '0) begin
			fw = FW'(1);
		end else if (32'(cfg.fb_width) > gbrc_pkg::FB_MAX_SIDE) begin
			fw = FW'(gbrc_pkg::FB_MAX_SIDE);
		end else begin
			fw = cfg.fb_width;
		end
		if (cfg.fb_height == '0) begin
			fh = FW'(1);
		end else if (32'(cfg.fb_height) > gbrc_pkg::FB_MAX_SIDE) begin
			fh = FW'(gbrc_pkg::FB_MAX_SIDE);
		end else begin
			fh = cfg.fb_height;
		end
	end

	always_comb begin
		case (cfg.paint_mode)
			gbrc_pkg::PAINT_SET:   paint = item.glyph_bit;
			gbrc_pkg::PAINT_CLEAR: paint = !item.glyph_bit;
			default:               paint = 1'b1;
		endcase
	end

	assign visible = paint
		&& !px[XW-1] && (px < $signed(XW'(fw)))
		&& !py[XW-1] && (py < $signed(XW'(fh)));

	assign wa    = 32'(cfg.bytes_per_pixel) >= gbrc_pkg::DEPTH_ALPHA;
	assign color = item.glyph_bit ? item.fg_color : item.bg_color;

	// inside the frame both coordinates fit the register width
	assign prod = (2*FW)'(px[FW-1:0]) * (2*FW)'(fh);
	assign lin  = AW'(prod) + AW'(py[FW-1:0]);
	assign addr = wa ? {lin[AW-3:0], 2'b00} : AW'({lin, 1'b0}) + lin;

	always_comb begin
		pix.pixel_byte_addr = addr;
		pix.red             = color[7:0];
		pix.green           = color[15:8];
		pix.blue            = color[23:16];
		pix.alpha           = wa ? color[31:24] : 8'd0;
		pix.write_alpha     = wa;
	end

endmodule
